@@ rtl/ttcdt_pkg.sv @@
// ttcdt_pkg: constants and pipeline stage types for the tick to civil date converter
// no dependencies; imported by ticks_to_civil_date_time
`timescale 1ns / 1ps

package ttcdt_pkg;

  // last tick of 9999-12-31 23:59:59.9999999
  localparam logic [61:0] LastTick = 62'd3155378975999999999;

  // ticks per day = 2^14 * 52734375, the odd part divided by reciprocal estimate
  localparam int DayShift = 14;
  localparam int TickHiWidth = 62 - DayShift;
  localparam int DayWidth = 22;
  localparam int DayRemWidth = 28;
  localparam logic [DayRemWidth-1:0] DayDivisor = 28'd52734375;
  localparam logic [DayRemWidth-1:0] DayDivisor2 = 28'd105468750;
  localparam logic [22:0] DayRecip = 23'((64'd1 << 48) / 64'd52734375);

  // ticks per second = 2^7 * 78125, same estimate and correction scheme
  localparam int FracWidth = 7;
  localparam int SecWidth = 17;
  localparam int SecRemWidth = 18;
  localparam logic [SecRemWidth-1:0] SecDivisor = 18'd78125;
  localparam logic [SecRemWidth-1:0] SecDivisor2 = 18'd156250;
  localparam logic [16:0] SecRecip = 17'((64'd1 << 33) / 64'd78125);

  // days from 0000-03-01 to 0001-01-01, and length of a 400 year era
  localparam logic [21:0] MarchOffset = 22'd306;
  localparam logic [21:0] EraDays = 22'd146097;
  localparam logic [17:0] CenturyDays = 18'd36524;
  localparam logic [17:0] LastEraDay = 18'd146096;

  // reciprocals for exact constant division: ceil(2^s / d)
  localparam logic [22:0] EraRecip = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
  localparam logic [18:0] QuadRecip = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] YearRecip = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [11:0] MonthRecip = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [11:0] FifthRecip = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
  localparam logic [17:0] HourRecip = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] MinRecip = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

  // payload carried through every pipeline stage
  typedef struct packed {
    logic                   oor;
    logic [TickHiWidth-1:0] x;
    logic [FracWidth-1:0]   tfrac;
    logic [DayWidth-1:0]    days;
    logic [DayRemWidth-1:0] drem;
    logic [SecWidth-1:0]    secs;
    logic [SecRemWidth-1:0] srem;
    logic [4:0]             hour;
    logic [11:0]            rest;
    logic [5:0]             minute;
    logic [5:0]             sec;
    logic [21:0]            shifted;
    logic [4:0]             era;
    logic [17:0]            doe;
    logic [17:0]            tt;
    logic [8:0]             yoe;
    logic [8:0]             doy;
    logic [3:0]             mp;
    logic [10:0]            v;
    logic [13:0]            year;
    logic [3:0]             month;
    logic [4:0]             dom;
  } stage_t;

endpackage

@@ rtl/ticks_to_civil_date_time.sv @@
// Throughput: one conversion per cycle while the output is not stalled, through 12 register
// stages (input register, day split by reciprocal estimate and correction, then calendar
// arithmetic alongside the second split and hour, minute and second extraction).
// A stall on the output holds every stage. Reset clears the valid bits only.
// ticks_to_civil_date_time: 100 ns tick count to Gregorian date and time of day
// depends on ttcdt_pkg
`timescale 1ns / 1ps

module ticks_to_civil_date_time (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_stall,
  input  logic [61:0] tick_count,
  output logic        date_valid,
  input  logic        date_stall,
  output logic [13:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  seconds,
  output logic        past_end
);
  import ttcdt_pkg::*;

  // time of day stage numbering
  localparam int DayEstStep = 1;
  localparam int DayRemStep = 2;
  localparam int DayFixStep = 3;
  localparam int SecEstStep = 4;
  localparam int SecRemStep = 5;
  localparam int SecFixStep = 6;
  localparam int HourStep   = 7;
  localparam int RestStep   = 8;
  localparam int MinStep    = 9;
  localparam int SecStep    = 10;

  // calendar stage numbering
  localparam int EraStep    = 4;
  localparam int DoeStep    = 5;
  localparam int QuadStep   = 6;
  localparam int YoeStep    = 7;
  localparam int DoyStep    = 8;
  localparam int MpStep     = 9;
  localparam int VStep      = 10;
  localparam int DateStep   = 11;
  localparam int Stages     = DateStep;

  // stage k: one piece of the day split, clock work and date work
  function automatic stage_t stage_step(input stage_t p, input int k);
    stage_t n;
    logic [54:0]            day_prod;
    logic [DayRemWidth-1:0] day_back;
    logic [32:0]            sx;
    logic [40:0]            sec_prod;
    logic [SecRemWidth-1:0] sec_back;
    logic [44:0] era_prod;
    logic [21:0] era_base;
    logic [36:0] quad_prod;
    logic [2:0]  cent_cnt;
    logic [36:0] year_prod;
    logic [1:0]  yc_cnt;
    logic [17:0] year_base;
    logic [10:0] mp_num;
    logic [22:0] mp_prod;
    logic [22:0] dd_prod;
    logic [8:0]  dd;
    logic [8:0]  dom_full;
    logic [3:0]  mon;
    logic [34:0] hour_prod;
    logic [24:0] min_prod;
    n = p;
    // time of day in units of 128 ticks
    sx = {p.drem[25:0], p.tfrac};
    // day count, seconds of day and clock fields
    case (k)
      DayEstStep: begin
        // estimate from the top bits, at most two below the true quotient
        day_prod = 55'(p.x[TickHiWidth-1:16]) * 55'(DayRecip);
        n.days = day_prod[53:32];
      end
      DayRemStep: begin
        day_back = DayRemWidth'(p.days) * DayDivisor;
        n.drem = p.x[DayRemWidth-1:0] - day_back;
      end
      DayFixStep: begin
        if (p.drem >= DayDivisor2) begin
          n.drem = p.drem - DayDivisor2;
          n.days = p.days + DayWidth'(2);
        end else if (p.drem >= DayDivisor) begin
          n.drem = p.drem - DayDivisor;
          n.days = p.days + DayWidth'(1);
        end
      end
      SecEstStep: begin
        sec_prod = 41'(sx[32:9]) * 41'(SecRecip);
        n.secs = sec_prod[40:24];
      end
      SecRemStep: begin
        sec_back = SecRemWidth'(p.secs) * SecDivisor;
        n.srem = sx[SecRemWidth-1:0] - sec_back;
      end
      SecFixStep: begin
        if (p.srem >= SecDivisor2) begin
          n.secs = p.secs + SecWidth'(2);
        end else if (p.srem >= SecDivisor) begin
          n.secs = p.secs + SecWidth'(1);
        end
      end
      HourStep: begin
        hour_prod = 35'(p.secs) * 35'(HourRecip);
        n.hour = hour_prod[33:29];
      end
      RestStep: begin
        n.rest = 12'(p.secs - 17'(p.hour) * 17'd3600);
      end
      MinStep: begin
        min_prod = 25'(p.rest) * 25'(MinRecip);
        n.minute = min_prod[23:18];
      end
      SecStep: begin
        n.sec = 6'(p.rest - 12'(p.minute) * 12'd60);
      end
      default: begin
      end
    endcase
    // calendar date from the day count
    case (k)
      EraStep: begin
        n.shifted = p.days + MarchOffset;
        era_prod = 45'(n.shifted) * 45'(EraRecip);
        n.era = era_prod[44:40];
      end
      DoeStep: begin
        era_base = 22'(p.era) * EraDays;
        n.doe = 18'(p.shifted - era_base);
      end
      QuadStep: begin
        quad_prod = 37'(p.doe) * 37'(QuadRecip);
        cent_cnt = 3'(p.doe >= CenturyDays) + 3'(p.doe >= 18'(2 * CenturyDays))
                 + 3'(p.doe >= 18'(3 * CenturyDays)) + 3'(p.doe >= 18'(4 * CenturyDays));
        n.tt = p.doe - 18'(quad_prod[35:29]) + 18'(cent_cnt) - 18'(p.doe == LastEraDay);
      end
      YoeStep: begin
        year_prod = 37'(p.tt) * 37'(YearRecip);
        n.yoe = year_prod[35:27];
      end
      DoyStep: begin
        yc_cnt = 2'(p.yoe >= 9'd100) + 2'(p.yoe >= 9'd200) + 2'(p.yoe >= 9'd300);
        year_base = 18'(p.yoe) * 18'd365 + 18'(p.yoe[8:2]) - 18'(yc_cnt);
        n.doy = 9'(p.doe - year_base);
      end
      MpStep: begin
        mp_num = 11'(p.doy) * 11'd5 + 11'd2;
        mp_prod = 23'(mp_num) * 23'(MonthRecip);
        n.mp = mp_prod[22:19];
      end
      VStep: begin
        n.v = 11'(p.mp) * 11'd153 + 11'd2;
      end
      DateStep: begin
        dd_prod = 23'(p.v) * 23'(FifthRecip);
        dd = dd_prod[22:14];
        dom_full = p.doy - dd + 9'd1;
        n.dom = dom_full[4:0];
        mon = (p.mp < 4'd10) ? 4'(p.mp + 4'd3) : 4'(p.mp - 4'd9);
        n.month = mon;
        n.year = 14'(p.yoe) + 14'(p.era) * 14'd400 + 14'(mon <= 4'd2);
      end
      default: begin
      end
    endcase
    return n;
  endfunction

  stage_t          pipe [0:Stages];
  logic [Stages:0] vld;
  logic            adv;
  logic            in_oor;
  logic [61:0]     in_src;
  stage_t          entry;

  // whole pipe moves unless a finished result is held
  assign adv        = !(vld[Stages] && date_stall);
  assign tick_stall = !adv;

  // range check and split of the tick count
  always_comb begin
    in_oor      = tick_count > LastTick;
    in_src      = in_oor ? '0 : tick_count;
    entry       = '0;
    entry.oor   = in_oor;
    entry.x     = in_src[61:DayShift];
    entry.tfrac = in_src[DayShift-1:DayShift-FracWidth];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Stages-1:0], tick_valid};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= entry;
    end
  end

  // conversion stages
  for (genvar k = 1; k <= Stages; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[k] <= stage_step(pipe[k-1], k);
      end
    end
  end

  // output, fields cleared when out of range
  assign date_valid   = vld[Stages];
  assign past_end     = pipe[Stages].oor;
  assign year         = past_end ? '0 : pipe[Stages].year;
  assign month        = past_end ? '0 : pipe[Stages].month;
  assign day_of_month = past_end ? '0 : pipe[Stages].dom;
  assign hour         = past_end ? '0 : pipe[Stages].hour;
  assign minute       = past_end ? '0 : pipe[Stages].minute;
  assign seconds      = past_end ? '0 : pipe[Stages].sec;

endmodule

@@ dv/ticks_to_civil_date_time_tb.sv @@
// ticks_to_civil_date_time_tb: checks tick count to calendar date and time of day conversion
// drives random and boundary tick counts with random idling, predicts each date in-bench
// depends on ttcdt_pkg and ticks_to_civil_date_time
`timescale 1ns / 1ps

module ticks_to_civil_date_time_tb;

  import ttcdt_pkg::LastTick;

  localparam logic [63:0] TicksPerSecond = 64'd10000000;
  localparam logic [63:0] TicksPerMinute = TicksPerSecond * 64'd60;
  localparam logic [63:0] TicksPerHour = TicksPerMinute * 64'd60;
  localparam logic [63:0] TicksPerDay = TicksPerHour * 64'd24;
  localparam logic [63:0] AllTicks = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam int unsigned RandomTicks = 1130;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned MaxPrinted = 40;

  typedef enum int unsigned {
    KIND_CALENDAR,
    KIND_UNIFORM,
    KIND_PAST_END
  } tick_kind_e;

  typedef struct packed {
    logic        oor;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
  } civil_t;

  typedef struct {
    logic [61:0] ticks;
    civil_t      date;
  } date_due_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        tick_valid = 1'b0;
  logic        tick_stall;
  logic [61:0] tick_count = '0;
  logic        date_valid;
  logic        date_stall = 1'b0;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  seconds;
  logic        past_end;

  logic [61:0] tick_pending[$];
  date_due_t   date_expected[$];

  int unsigned n_errors = 0;
  int unsigned n_ticks = 0;
  int unsigned n_past_end = 0;
  int unsigned n_dates = 0;
  int unsigned n_calendar = 0;
  bit          long_hold = 1'b0;

  int unsigned tx_wait = 0;
  int unsigned tx_left = 0;
  bit          tx_calm = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned rx_left = 0;
  bit          rx_calm = 1'b0;

  ticks_to_civil_date_time i_dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick_count   (tick_count),
    .date_valid   (date_valid),
    .date_stall   (date_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .seconds      (seconds),
    .past_end     (past_end)
  );

  // expected date and time of day for one tick count
  function automatic civil_t civil_from_ticks(input logic [61:0] ticks);
    civil_t      c;
    logic [63:0] days, tod, march, era, doe, yoe, doy, mp;
    c = '0;
    if (ticks > LastTick) begin
      c.oor = 1'b1;
    end else begin
      days = 64'(ticks) / TicksPerDay;
      tod = 64'(ticks) % TicksPerDay;
      // count from 0000-03-01 so the leap day closes each year
      march = days + 64'd306;
      era = march / 64'd146097;
      doe = march - era * 64'd146097;
      yoe = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
      doy = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
      mp = (64'd5 * doy + 64'd2) / 64'd153;
      c.month = (mp < 64'd10) ? 4'(mp + 64'd3) : 4'(mp - 64'd9);
      c.dom = 5'(doy - (64'd153 * mp + 64'd2) / 64'd5 + 64'd1);
      c.year = 14'(yoe + era * 64'd400 + ((mp >= 64'd10) ? 64'd1 : 64'd0));
      c.hour = 5'(tod / TicksPerHour);
      c.minute = 6'((tod % TicksPerHour) / TicksPerMinute);
      c.sec = 6'((tod % TicksPerMinute) / TicksPerSecond);
    end
    return c;
  endfunction

  // days from 0001-01-01 to january 1st of the given year
  function automatic logic [63:0] days_before_year(input int unsigned y);
    logic [63:0] p;
    p = 64'(y - 1);
    return 64'd365 * p + p / 64'd4 - p / 64'd100 + p / 64'd400;
  endfunction

  function automatic logic [61:0] ticks_at(input int unsigned y, input logic [63:0] day_of_year,
                                           input logic [63:0] tod);
    return 62'((days_before_year(y) + day_of_year) * TicksPerDay + tod);
  endfunction

  function automatic logic [63:0] random64();
    return {$urandom, $urandom};
  endfunction

  // per-item wait, with stretches where a side never idles
  function automatic int unsigned next_wait(inout int unsigned left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(20, 120);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MaxPrinted) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [13:0] got,
                               input logic [13:0] want, input logic [61:0] ticks);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d want %0d for tick %0d", name, got, want, ticks));
    end
  endtask

  // a date-shaped tick count: year edges, leap days and century years
  function automatic logic [61:0] random_calendar_tick();
    int unsigned y;
    logic [63:0] year_len, doy, tod;
    case ($urandom_range(0, 3))
      0: y = 100 * $urandom_range(1, 99);
      1: y = 400 * $urandom_range(1, 24);
      default: y = $urandom_range(1, 9999);
    endcase
    year_len = days_before_year(y + 1) - days_before_year(y);
    case ($urandom_range(0, 5))
      0: doy = 64'd0;
      1: doy = 64'd58;
      2: doy = 64'd59;
      3: doy = 64'd60;
      4: doy = year_len - 64'd1;
      default: doy = 64'($urandom_range(0, 32'(year_len) - 1));
    endcase
    case ($urandom_range(0, 3))
      0: tod = 64'd0;
      1: tod = TicksPerDay - 64'd1;
      2: tod = 64'($urandom_range(1, 86399)) * TicksPerSecond - 64'd1;
      default: tod = random64() % TicksPerDay;
    endcase
    return ticks_at(y, doy, tod);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender: offers queued tick counts, predicts each on transfer
  always @(posedge clk) begin : tick_driver
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!tick_valid || !tick_stall) begin
      if (tick_valid) begin
        date_expected.push_back('{ticks: tick_count, date: civil_from_ticks(tick_count)});
        n_ticks++;
        if (tick_count > LastTick) n_past_end++;
      end
      if (tx_wait > 0) begin
        tx_wait--;
        tick_valid <= 1'b0;
      end else if (tick_pending.size() > 0) begin
        tick_count <= tick_pending.pop_front();
        tick_valid <= 1'b1;
        tx_wait = next_wait(tx_left, tx_calm);
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // receiver: checks each date transfer against the oldest prediction
  always @(posedge clk) begin : date_monitor
    civil_t    seen;
    date_due_t due;
    if (rst) begin
      date_stall <= 1'b0;
    end else begin
      if (date_valid && !date_stall) begin
        seen.oor = past_end;
        seen.year = year;
        seen.month = month;
        seen.dom = day_of_month;
        seen.hour = hour;
        seen.minute = minute;
        seen.sec = seconds;
        n_dates++;
        if (date_expected.size() == 0) begin
          report_mismatch("date transfer with no tick count outstanding");
        end else begin
          due = date_expected.pop_front();
          compare_field("past_end", 14'(seen.oor), 14'(due.date.oor), due.ticks);
          compare_field("year", seen.year, due.date.year, due.ticks);
          compare_field("month", 14'(seen.month), 14'(due.date.month), due.ticks);
          compare_field("day_of_month", 14'(seen.dom), 14'(due.date.dom), due.ticks);
          compare_field("hour", 14'(seen.hour), 14'(due.date.hour), due.ticks);
          compare_field("minute", 14'(seen.minute), 14'(due.date.minute), due.ticks);
          compare_field("seconds", 14'(seen.sec), 14'(due.date.sec), due.ticks);
        end
        rx_wait = next_wait(rx_left, rx_calm);
      end
      if (long_hold) begin
        date_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        date_stall <= 1'b1;
      end else begin
        date_stall <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the pipeline fills and pushes back on the sender
  initial begin
    wait (n_dates >= 300);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    long_hold <= 1'b0;
  end

  // overall time limit
  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  // stimulus, reset and end of run
  initial begin
    tick_kind_e kind;
    logic [63:0] r;

    // directed: range ends, day edges, leap days, bit patterns
    tick_pending.push_back(62'd0);
    tick_pending.push_back(62'd1);
    tick_pending.push_back(62'(TicksPerDay - 64'd1));
    tick_pending.push_back(62'(TicksPerDay));
    tick_pending.push_back(ticks_at(4, 64'd59, 64'd0));
    tick_pending.push_back(ticks_at(1900, 64'd58, TicksPerDay - 64'd1));
    tick_pending.push_back(ticks_at(1900, 64'd59, 64'd0));
    tick_pending.push_back(ticks_at(2000, 64'd59, TicksPerHour * 64'd12));
    tick_pending.push_back(ticks_at(2000, 64'd365, TicksPerDay - 64'd1));
    tick_pending.push_back(ticks_at(400, 64'd365, TicksPerDay - 64'd1));
    tick_pending.push_back(ticks_at(401, 64'd0, 64'd0));
    tick_pending.push_back(ticks_at(2400, 64'd59, TicksPerMinute * 64'd61 + 64'd7));
    tick_pending.push_back(ticks_at(1970, 64'd0,
                                    TicksPerHour * 64'd12 + TicksPerMinute * 64'd34 +
                                    TicksPerSecond * 64'd56 + 64'd7));
    tick_pending.push_back(ticks_at(9999, 64'd364, 64'd0));
    tick_pending.push_back(62'(64'(LastTick) - TicksPerSecond));
    tick_pending.push_back(LastTick);
    tick_pending.push_back(62'(64'(LastTick) + 64'd1));
    tick_pending.push_back(62'(AllTicks));
    tick_pending.push_back(62'h2AAA_AAAA_AAAA_AAAA);
    tick_pending.push_back(62'h1555_5555_5555_5555);
    tick_pending.push_back(62'h2000_0000_0000_0000);
    tick_pending.push_back(62'h1FFF_FFFF_FFFF_FFFF);

    // random: mostly dates near interesting edges and uniform in range
    for (int unsigned i = 0; i < RandomTicks; i++) begin
      r = random64();
      case ($urandom_range(0, 19))
        0, 1, 2: kind = KIND_PAST_END;
        3, 4, 5, 6, 7, 8, 9, 10, 11: kind = KIND_CALENDAR;
        default: kind = KIND_UNIFORM;
      endcase
      case (kind)
        KIND_CALENDAR: begin
          tick_pending.push_back(random_calendar_tick());
          n_calendar++;
        end
        KIND_PAST_END: begin
          tick_pending.push_back(62'(64'(LastTick) + 64'd1 + r % (AllTicks - 64'(LastTick))));
        end
        default: begin
          tick_pending.push_back(62'(r % (64'(LastTick) + 64'd1)));
        end
      endcase
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (tick_pending.size() == 0 && !tick_valid);
    wait (date_expected.size() == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("converted %0d tick counts, %0d past the end of year 9999, %0d date-shaped",
             n_ticks, n_past_end, n_calendar);
    $display("checked %0d date transfers with random idling and a %0d cycle output hold-off",
             n_dates, HoldCycles);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
